// ===== design/matrix_inverse_3x3_macros.svh =====
// Assertion macros used by the matrix inverse design (matrix_inverse_3x3.sv).
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define MI3_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define MI3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MI3_ASSERT(lbl, clk, rst_n, prop, msg)
`define MI3_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/mi3_pkg.sv =====
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef struct packed {
    logic neg;
    logic singular;
  } mi3_ctl_t;

endpackage

// ===== design/mi3_in_if.sv =====
interface mi3_in_if #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a00;
  logic signed [DATA_WIDTH-1:0] a01;
  logic signed [DATA_WIDTH-1:0] a02;
  logic signed [DATA_WIDTH-1:0] a10;
  logic signed [DATA_WIDTH-1:0] a11;
  logic signed [DATA_WIDTH-1:0] a12;
  logic signed [DATA_WIDTH-1:0] a20;
  logic signed [DATA_WIDTH-1:0] a21;
  logic signed [DATA_WIDTH-1:0] a22;

  modport source (
    output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
    input  ready
  );
  modport sink (
    input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
    output ready
  );
endinterface

// ===== design/mi3_out_if.sv =====
interface mi3_out_if #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r00;
  logic signed [DATA_WIDTH-1:0] r01;
  logic signed [DATA_WIDTH-1:0] r02;
  logic signed [DATA_WIDTH-1:0] r10;
  logic signed [DATA_WIDTH-1:0] r11;
  logic signed [DATA_WIDTH-1:0] r12;
  logic signed [DATA_WIDTH-1:0] r20;
  logic signed [DATA_WIDTH-1:0] r21;
  logic signed [DATA_WIDTH-1:0] r22;
  logic                         singular;
  logic                         saturated;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, saturated,
    output ready
  );
endinterface

// ===== design/mi3_div.sv =====
module mi3_div #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int NUM_WIDTH  = 4 * mi3_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [NUM_WIDTH-1:0]   num_i,
  input  logic [NUM_WIDTH-1:0]   den_i,
  input  mi3_pkg::mi3_ctl_t      ctl_i,
  output logic [DATA_WIDTH-1:0]  quo_o,
  output logic                   sat_o,
  output mi3_pkg::mi3_ctl_t      ctl_o
);
  import mi3_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NW = NUM_WIDTH;

  logic [NW-1:0] rem_d [W+1];
  logic [NW-1:0] rem_q [W+1];
  logic [NW-1:0] den_q [W+1];
  logic [W-1:0]  quo_d [W+1];
  logic [W-1:0]  quo_q [W+1];
  logic [W:0]    ovf_q;
  mi3_ctl_t      ctl_q [W+1];
  logic [NW-1:0] trial [W];
  logic [W-1:0]  ge;

  logic          pos_sat;
  logic          neg_sat;
  logic [W-1:0]  res_d;
  logic [W-1:0]  res_q;
  logic          sat_d;
  logic          sat_q;
  mi3_ctl_t      cto_q;

  // One quotient bit per stage, most significant first.
  always_comb begin
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int j = 0; j < W; j++) begin
      trial[j]   = den_q[j] << (W - 1 - j);
      ge[j]      = rem_q[j] >= trial[j];
      rem_d[j+1] = ge[j] ? rem_q[j] - trial[j] : rem_q[j];
      quo_d[j+1] = quo_q[j] | (W'(ge[j]) << (W - 1 - j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= num_i >= (den_i << W);
      den_q[0] <= den_i;
      ctl_q[0] <= ctl_i;
      for (int i = 0; i <= W; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
      for (int i = 1; i <= W; i++) begin
        ovf_q[i] <= ovf_q[i-1];
        den_q[i] <= den_q[i-1];
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // The quotient magnitude saturates one step later on the negative side.
  always_comb begin
    pos_sat = ovf_q[W] || quo_q[W][W-1];
    neg_sat = ovf_q[W] || (quo_q[W][W-1] && (quo_q[W][W-2:0] != '0));
    sat_d   = 1'b0;
    if (ctl_q[W].singular) begin
      res_d = '0;
    end else if (!ctl_q[W].neg && pos_sat) begin
      res_d = {1'b0, {(W-1){1'b1}}};
      sat_d = 1'b1;
    end else if (ctl_q[W].neg && neg_sat) begin
      res_d = {1'b1, {(W-1){1'b0}}};
      sat_d = 1'b1;
    end else begin
      res_d = ctl_q[W].neg ? -quo_q[W] : quo_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      sat_q <= sat_d;
      cto_q <= ctl_q[W];
    end
  end

  assign quo_o = res_q;
  assign sat_o = sat_q;
  assign ctl_o = cto_q;

endmodule

// ===== design/matrix_inverse_3x3.sv =====
// Inverts one row-major 3x3 matrix of signed fixed-point entries per transaction
// (DATA_WIDTH bits, FRAC_BITS fraction bits) through the adjugate and a
// first-row determinant, both formed exactly. Each inverse entry is the
// adjugate entry scaled by 2^(2*FRAC_BITS) and divided by the determinant,
// truncated toward zero and clipped to the entry range, with saturated set
// when any entry clips. A zero determinant gives zero entries and sets
// singular. A new matrix is taken in every cycle while the output does not
// stall. Six stages form the products, cofactors, determinant and
// magnitudes, and nine restoring dividers spend one stage per quotient bit
// plus a range check and a saturation stage. A stall at the output holds
// the whole pipeline.
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int AW  = 2 * W + 1;
  localparam int SW  = 2 * W + 3;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = 4 * W;
  localparam int LAT = W + 8;

  // Operand indexes of each cofactor p*q - s*t, in adjugate order.
  localparam int COF_IDX [36] = '{
    4, 8, 5, 7,  2, 7, 1, 8,  1, 5, 2, 4,
    5, 6, 3, 8,  0, 8, 2, 6,  2, 3, 0, 5,
    3, 7, 4, 6,  1, 6, 0, 7,  0, 4, 1, 3
  };

  logic           en;
  logic [LAT-1:0] v_q;

  logic signed [W-1:0]  a      [9];
  logic signed [PW-1:0] prod_d [18];
  logic signed [PW-1:0] prod_q [18];
  logic signed [W-1:0]  a1_q   [3];
  logic signed [W-1:0]  a2_q   [3];
  logic signed [AW-1:0] adj_d  [9];
  logic signed [AW-1:0] adj2_q [9];
  logic signed [AW-1:0] adj3_q [9];
  logic signed [AW-1:0] adj4_q [9];
  logic signed [AW-1:0] adj5_q [9];
  logic signed [AW-1:0] ph_d   [3];
  logic signed [AW-1:0] ph_q   [3];
  logic signed [AW-1:0] pl_d   [3];
  logic signed [AW-1:0] pl_q   [3];
  logic signed [SW-1:0] hs_d;
  logic signed [SW-1:0] hs_q;
  logic signed [SW-1:0] ls_d;
  logic signed [SW-1:0] ls_q;
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;
  logic [AW-1:0]        adj_mag [9];
  logic [DW-1:0]        det_mag;
  logic [NW-1:0]        num_d  [9];
  logic [NW-1:0]        num_q  [9];
  logic [NW-1:0]        den_d;
  logic [NW-1:0]        den_q;
  mi3_ctl_t             ctl_d  [9];
  mi3_ctl_t             ctl_q  [9];
  logic [W-1:0]         quo    [9];
  logic [8:0]           sat;
  mi3_ctl_t             ctl_out [9];

  assign en       = !v_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  assign a[0] = in_i.a00;
  assign a[1] = in_i.a01;
  assign a[2] = in_i.a02;
  assign a[3] = in_i.a10;
  assign a[4] = in_i.a11;
  assign a[5] = in_i.a12;
  assign a[6] = in_i.a20;
  assign a[7] = in_i.a21;
  assign a[8] = in_i.a22;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_d[2*k]   = a[COF_IDX[4*k]] * a[COF_IDX[4*k+1]];
      prod_d[2*k+1] = a[COF_IDX[4*k+2]] * a[COF_IDX[4*k+3]];
      adj_d[k]      = AW'(prod_q[2*k]) - AW'(prod_q[2*k+1]);
    end
    // The determinant terms are split into a signed upper half and an
    // unsigned lower half of the cofactor to keep each multiplier narrow.
    for (int k = 0; k < 3; k++) begin
      ph_d[k] = a2_q[k] * $signed(adj2_q[3*k][AW-1:W]);
      pl_d[k] = a2_q[k] * $signed({1'b0, adj2_q[3*k][W-1:0]});
    end
    hs_d  = SW'(ph_q[0]) + SW'(ph_q[1]) + SW'(ph_q[2]);
    ls_d  = SW'(pl_q[0]) + SW'(pl_q[1]) + SW'(pl_q[2]);
    det_d = (DW'(hs_q) <<< W) + DW'(ls_q);
    det_mag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    den_d   = NW'(det_mag);
    for (int k = 0; k < 9; k++) begin
      adj_mag[k]        = adj5_q[k][AW-1] ? AW'(-adj5_q[k]) : AW'(adj5_q[k]);
      num_d[k]          = NW'(adj_mag[k]) << (2 * FRAC_BITS);
      ctl_d[k].neg      = adj5_q[k][AW-1] ^ det_q[DW-1];
      ctl_d[k].singular = det_q == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      for (int i = 0; i < 3; i++) begin
        a1_q[i] <= a[i];
        a2_q[i] <= a1_q[i];
      end
      adj2_q <= adj_d;
      adj3_q <= adj2_q;
      adj4_q <= adj3_q;
      adj5_q <= adj4_q;
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      hs_q   <= hs_d;
      ls_q   <= ls_d;
      det_q  <= det_d;
      num_q  <= num_d;
      den_q  <= den_d;
      ctl_q  <= ctl_d;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    mi3_div #(
      .DATA_WIDTH(W),
      .NUM_WIDTH (NW)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_q[k]),
      .den_i(den_q),
      .ctl_i(ctl_q[k]),
      .quo_o(quo[k]),
      .sat_o(sat[k]),
      .ctl_o(ctl_out[k])
    );
  end

  assign out_o.valid     = v_q[LAT-1];
  assign out_o.r00       = quo[0];
  assign out_o.r01       = quo[1];
  assign out_o.r02       = quo[2];
  assign out_o.r10       = quo[3];
  assign out_o.r11       = quo[4];
  assign out_o.r12       = quo[5];
  assign out_o.r20       = quo[6];
  assign out_o.r21       = quo[7];
  assign out_o.r22       = quo[8];
  assign out_o.singular  = ctl_out[0].singular;
  assign out_o.saturated = |sat;

  `MI3_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> v_q == '0, "pipeline not empty in reset")
  `MI3_ASSERT(a_accept_enters, clk_i, rst_ni, in_i.valid && in_i.ready |=> v_q[0], "accepted transaction lost")
  `MI3_ASSERT(a_stall_holds, clk_i, rst_ni, !en |=> $stable(v_q), "pipeline moved while stalled")
  `MI3_ASSERT(a_singular_zero, clk_i, rst_ni, out_o.valid && out_o.singular |-> !out_o.saturated && out_o.r00 == '0 && out_o.r22 == '0, "singular result not cleared")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DW = mi3_pkg::DATA_WIDTH_DEF;
  localparam int FB = mi3_pkg::FRAC_BITS_DEF;
  localparam int NUM_RANDOM = 1700;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ONE = 1 << FB;

  typedef logic signed [DW-1:0] entry_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    entry_t a[9];
  } matrix_t;

  typedef struct {
    entry_t r[9];
    logic   singular;
    logic   saturated;
  } inverse_t;

  function automatic inverse_t invert(matrix_t m);
    wide_t    a[9];
    wide_t    adj[9];
    wide_t    det;
    wide_t    q;
    wide_t    hi;
    wide_t    lo;
    inverse_t res;
    for (int i = 0; i < 9; i++) a[i] = m.a[i];
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    res.singular  = 1'b0;
    res.saturated = 1'b0;
    if (det == 0) begin
      for (int i = 0; i < 9; i++) res.r[i] = '0;
      res.singular = 1'b1;
      return res;
    end
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 9; i++) begin
      q = (adj[i] <<< (2 * FB)) / det;
      if (q > hi) begin
        q = hi;
        res.saturated = 1'b1;
      end else if (q < lo) begin
        q = lo;
        res.saturated = 1'b1;
      end
      res.r[i] = q[DW-1:0];
    end
    return res;
  endfunction

  class inverse_scoreboard;
    inverse_t pending[$];
    int       failures;

    function void note_matrix(matrix_t m);
      pending.push_back(invert(m));
    endfunction

    function void check_result(inverse_t got);
      inverse_t exp;
      logic     bad;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result transaction at %0t.", $realtime);
        return;
      end
      exp = pending.pop_front();
      bad = (got.singular !== exp.singular) || (got.saturated !== exp.saturated);
      for (int i = 0; i < 9; i++) if (got.r[i] !== exp.r[i]) bad = 1'b1;
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("Mismatch at %0t: singular %b/%b saturated %b/%b (expected/actual).",
                   $realtime, exp.singular, got.singular, exp.saturated, got.saturated);
          for (int i = 0; i < 9; i++)
            $display("  r%0d%0d expected %h actual %h", i / 3, i % 3, exp.r[i], got.r[i]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycles = 0;
  int   results_seen = 0;
  bit   send_burst = 1'b0;
  bit   recv_burst = 1'b0;

  inverse_scoreboard sb = new();

  mi3_in_if  #(.DATA_WIDTH(DW)) in_if ();
  mi3_out_if #(.DATA_WIDTH(DW)) out_if ();

  matrix_inverse_3x3 #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_matrix(matrix_t m);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.a00 <= m.a[0];
    in_if.a01 <= m.a[1];
    in_if.a02 <= m.a[2];
    in_if.a10 <= m.a[3];
    in_if.a11 <= m.a[4];
    in_if.a12 <= m.a[5];
    in_if.a20 <= m.a[6];
    in_if.a21 <= m.a[7];
    in_if.a22 <= m.a[8];
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    sb.note_matrix(m);
  endtask

  function automatic matrix_t diag(entry_t d0, entry_t d1, entry_t d2);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = d0;
    m.a[4] = d1;
    m.a[8] = d2;
    return m;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    int      span;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 1) ? 4 : 64) * ONE;
    for (int i = 0; i < 9; i++) begin
      if (kind < 50) m.a[i] = $signed($urandom_range(0, 2 * span)) - span;
      else if (kind < 70) m.a[i] = $urandom;
      else if (kind < 85) m.a[i] = $signed($urandom_range(0, 512)) - 256;
      else m.a[i] = $signed($urandom_range(0, 2 * span)) - span;
    end
    if (kind >= 85) begin
      case ($urandom_range(0, 2))
        0: for (int c = 0; c < 3; c++) m.a[6 + c] = m.a[c];
        1: for (int r = 0; r < 3; r++) m.a[3 * r + 2] = m.a[3 * r];
        default: for (int c = 0; c < 3; c++) m.a[3 + c] = '0;
      endcase
    end
    if (kind < 50 && $urandom_range(0, 1)) begin
      m.a[0] = m.a[0] + 8 * ONE;
      m.a[4] = m.a[4] + 8 * ONE;
      m.a[8] = m.a[8] + 8 * ONE;
    end
    return m;
  endfunction

  initial begin
    matrix_t m;
    matrix_t directed[$];
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.a00    <= '0;
    in_if.a01    <= '0;
    in_if.a02    <= '0;
    in_if.a10    <= '0;
    in_if.a11    <= '0;
    in_if.a12    <= '0;
    in_if.a20    <= '0;
    in_if.a21    <= '0;
    in_if.a22    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(diag(ONE, ONE, ONE));
    directed.push_back(diag(0, 0, 0));
    directed.push_back(diag(2 * ONE, -4 * ONE, ONE / 2));
    directed.push_back(diag(1, 1, 1));
    directed.push_back(diag(-1, 1, 1));
    directed.push_back(diag(entry_t'(32'h7fffffff), entry_t'(32'h7fffffff),
                            entry_t'(32'h7fffffff)));
    directed.push_back(diag(entry_t'(32'h80000000), entry_t'(32'h80000000),
                            entry_t'(32'h80000000)));
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(32'h7fffffff);
    directed.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(32'h80000000);
    directed.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? entry_t'(32'h80000000) : entry_t'(32'h7fffffff);
    directed.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[1] = ONE;
    m.a[5] = ONE;
    m.a[6] = ONE;
    directed.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i + 1) * ONE;
    directed.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = 2 * ONE;
    m.a[1] = ONE;
    m.a[3] = ONE;
    m.a[4] = 3 * ONE;
    m.a[8] = -ONE;
    m.a[2] = -ONE;
    directed.push_back(m);
    directed.push_back(diag(entry_t'(32'h7fffffff), 1, entry_t'(32'h80000000)));
    directed.push_back(diag(ONE, -1, ONE));
    foreach (directed[i]) send_matrix(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_matrix(random_matrix());
    end
    in_if.valid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    inverse_t got;
    int       stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_seen % 100 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (results_seen == 300) stall = 700;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (!out_if.valid);
      got.r[0]      = out_if.r00;
      got.r[1]      = out_if.r01;
      got.r[2]      = out_if.r02;
      got.r[3]      = out_if.r10;
      got.r[4]      = out_if.r11;
      got.r[5]      = out_if.r12;
      got.r[6]      = out_if.r20;
      got.r[7]      = out_if.r21;
      got.r[8]      = out_if.r22;
      got.singular  = out_if.singular;
      got.saturated = out_if.saturated;
      @(posedge clk_i);
      sb.check_result(got);
      results_seen++;
    end
  end

endmodule
